@@ hdl/qvr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotation package
// Shared field widths and transaction types for the rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int VEC_BITS  = 24;
  localparam int QUAT_BITS = 16;
  localparam int COEF_BITS = 2 * QUAT_BITS + 2;
  localparam int NORM_BITS = 2 * QUAT_BITS + 1;
  localparam int PROD_BITS = COEF_BITS + VEC_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int MAG_BITS  = NORM_BITS + VEC_BITS;

  typedef logic signed [QUAT_BITS-1:0] quat_t;
  typedef logic signed [VEC_BITS-1:0]  vec_t;

  typedef struct packed {
    quat_t q_w;
    quat_t q_x;
    quat_t q_y;
    quat_t q_z;
    vec_t  vec_x;
    vec_t  vec_y;
    vec_t  vec_z;
  } qvr_in_t;

  typedef struct packed {
    vec_t rot_x;
    vec_t rot_y;
    vec_t rot_z;
    logic zero_quat;
    logic saturated;
  } qvr_out_t;

  typedef struct packed {
    logic [8:0][COEF_BITS-1:0] m;
    logic [2:0][VEC_BITS-1:0]  vec;
    logic [NORM_BITS-1:0]      n;
    logic                      zero;
  } qvr_mat_t;

  typedef struct packed {
    logic [2:0][MAG_BITS-1:0] rem;
    logic [2:0][VEC_BITS-1:0] quo;
    logic [2:0]               neg;
    logic [NORM_BITS-1:0]     n;
    logic                     zero;
  } qvr_div_t;

endpackage

@@ hdl/qvr_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix stages
// Forms the quaternion products, then the scaled rotation matrix and norm.
// ----------------------------------------------------------------------------
module qvr_matrix (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  qvr_pkg::qvr_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output qvr_pkg::qvr_mat_t out_data
);
  import qvr_pkg::*;

  typedef struct packed {
    logic signed [2*QUAT_BITS-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
    logic [2:0][VEC_BITS-1:0]      vec;
  } prod_t;

  prod_t    prod_r, prod_nxt;
  logic     prod_v_r;
  qvr_mat_t mat_r, mat_nxt;
  logic     mat_v_r;
  logic     rdy_a, rdy_b;

  assign rdy_b    = !mat_v_r || out_ready;
  assign rdy_a    = !prod_v_r || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    prod_nxt.ww  = in_data.q_w * in_data.q_w;
    prod_nxt.xx  = in_data.q_x * in_data.q_x;
    prod_nxt.yy  = in_data.q_y * in_data.q_y;
    prod_nxt.zz  = in_data.q_z * in_data.q_z;
    prod_nxt.xy  = in_data.q_x * in_data.q_y;
    prod_nxt.wz  = in_data.q_w * in_data.q_z;
    prod_nxt.xz  = in_data.q_x * in_data.q_z;
    prod_nxt.wy  = in_data.q_w * in_data.q_y;
    prod_nxt.yz  = in_data.q_y * in_data.q_z;
    prod_nxt.wx  = in_data.q_w * in_data.q_x;
    prod_nxt.vec = {in_data.vec_x, in_data.vec_y, in_data.vec_z};
  end

  always_comb begin
    mat_nxt.m[0] = COEF_BITS'(prod_r.ww) + COEF_BITS'(prod_r.xx)
                 - COEF_BITS'(prod_r.yy) - COEF_BITS'(prod_r.zz);
    mat_nxt.m[1] = (COEF_BITS'(prod_r.xy) - COEF_BITS'(prod_r.wz)) <<< 1;
    mat_nxt.m[2] = (COEF_BITS'(prod_r.xz) + COEF_BITS'(prod_r.wy)) <<< 1;
    mat_nxt.m[3] = (COEF_BITS'(prod_r.xy) + COEF_BITS'(prod_r.wz)) <<< 1;
    mat_nxt.m[4] = COEF_BITS'(prod_r.ww) - COEF_BITS'(prod_r.xx)
                 + COEF_BITS'(prod_r.yy) - COEF_BITS'(prod_r.zz);
    mat_nxt.m[5] = (COEF_BITS'(prod_r.yz) - COEF_BITS'(prod_r.wx)) <<< 1;
    mat_nxt.m[6] = (COEF_BITS'(prod_r.xz) - COEF_BITS'(prod_r.wy)) <<< 1;
    mat_nxt.m[7] = (COEF_BITS'(prod_r.yz) + COEF_BITS'(prod_r.wx)) <<< 1;
    mat_nxt.m[8] = COEF_BITS'(prod_r.ww) - COEF_BITS'(prod_r.xx)
                 - COEF_BITS'(prod_r.yy) + COEF_BITS'(prod_r.zz);
    mat_nxt.n    = NORM_BITS'($unsigned(prod_r.ww)) + NORM_BITS'($unsigned(prod_r.xx))
                 + NORM_BITS'($unsigned(prod_r.yy)) + NORM_BITS'($unsigned(prod_r.zz));
    mat_nxt.zero = (mat_nxt.n == '0);
    mat_nxt.vec  = prod_r.vec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      mat_v_r  <= 1'b0;
    end else begin
      if (rdy_a) prod_v_r <= in_valid;
      if (rdy_b) mat_v_r <= prod_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) prod_r <= prod_nxt;
    if (rdy_b && prod_v_r) mat_r <= mat_nxt;
  end

  assign out_valid = mat_v_r;
  assign out_data  = mat_r;

endmodule

@@ hdl/qvr_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix-vector stages
// Multiplies the matrix by the vector, sums rows and splits sign and magnitude.
// ----------------------------------------------------------------------------
module qvr_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qvr_pkg::qvr_mat_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qvr_pkg::qvr_div_t out_data
);
  import qvr_pkg::*;

  typedef struct packed {
    logic [8:0][PROD_BITS-1:0] p;
    logic [NORM_BITS-1:0]      n;
    logic                      zero;
  } mul_t;

  typedef struct packed {
    logic [2:0][SUM_BITS-1:0] s;
    logic [NORM_BITS-1:0]     n;
    logic                     zero;
  } sum_t;

  mul_t     mul_r, mul_nxt;
  sum_t     sum_r, sum_nxt;
  qvr_div_t mag_r, mag_nxt;
  logic     mul_v_r, sum_v_r, mag_v_r;
  logic     rdy_c, rdy_d, rdy_e;

  assign rdy_e    = !mag_v_r || out_ready;
  assign rdy_d    = !sum_v_r || rdy_e;
  assign rdy_c    = !mul_v_r || rdy_d;
  assign in_ready = rdy_c;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      mul_nxt.p[k] = PROD_BITS'($signed(in_data.m[k]) * $signed(in_data.vec[2 - (k % 3)]));
    end
    mul_nxt.n    = in_data.n;
    mul_nxt.zero = in_data.zero;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_nxt.s[i] = SUM_BITS'($signed(mul_r.p[3*i]))
                   + SUM_BITS'($signed(mul_r.p[3*i+1]))
                   + SUM_BITS'($signed(mul_r.p[3*i+2]));
    end
    sum_nxt.n    = mul_r.n;
    sum_nxt.zero = mul_r.zero;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_nxt.neg[i] = sum_r.s[i][SUM_BITS-1];
      mag_nxt.rem[i] = sum_r.s[i][SUM_BITS-1] ? MAG_BITS'(-sum_r.s[i]) : MAG_BITS'(sum_r.s[i]);
    end
    mag_nxt.quo  = '0;
    mag_nxt.n    = sum_r.n;
    mag_nxt.zero = sum_r.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      sum_v_r <= 1'b0;
      mag_v_r <= 1'b0;
    end else begin
      if (rdy_c) mul_v_r <= in_valid;
      if (rdy_d) sum_v_r <= mul_v_r;
      if (rdy_e) mag_v_r <= sum_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && in_valid) mul_r <= mul_nxt;
    if (rdy_d && mul_v_r) sum_r <= sum_nxt;
    if (rdy_e && sum_v_r) mag_r <= mag_nxt;
  end

  assign out_valid = mag_v_r;
  assign out_data  = mag_r;

endmodule

@@ hdl/qvr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division by the norm, one quotient bit per stage, then rounding
// to nearest, saturation and sign restore.
// ----------------------------------------------------------------------------
module qvr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qvr_pkg::qvr_div_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qvr_pkg::qvr_out_t out_data
);
  import qvr_pkg::*;

  localparam logic [VEC_BITS:0] LIM = (VEC_BITS+1)'(1) << (VEC_BITS - 1);

  qvr_div_t          st_r [VEC_BITS];
  logic [VEC_BITS-1:0] v_r;
  logic [VEC_BITS:0]   rdy;
  qvr_out_t          out_r, out_nxt;
  logic              out_v_r;

  assign rdy[VEC_BITS] = !out_v_r || out_ready;
  assign in_ready      = rdy[0];

  for (genvar s = 0; s < VEC_BITS; s++) begin : g_stage
    localparam int B = VEC_BITS - 1 - s;
    qvr_div_t            cur, nxt;
    logic                cv;
    logic [MAG_BITS-1:0] dsh;

    if (s == 0) begin : g_first
      assign cur = in_data;
      assign cv  = in_valid;
    end else begin : g_next
      assign cur = st_r[s-1];
      assign cv  = v_r[s-1];
    end

    assign rdy[s] = !v_r[s] || rdy[s+1];
    assign dsh    = MAG_BITS'(cur.n) << B;

    always_comb begin
      nxt = cur;
      for (int k = 0; k < 3; k++) begin
        if (cur.rem[k] >= dsh) begin
          nxt.rem[k]    = cur.rem[k] - dsh;
          nxt.quo[k][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && cv) st_r[s] <= nxt;
    end
  end

  always_comb begin
    qvr_div_t          fin;
    logic [VEC_BITS:0] qr;
    logic              half;
    logic [2:0]        sat;
    vec_t              res [3];
    fin = st_r[VEC_BITS-1];
    for (int k = 0; k < 3; k++) begin
      half   = {fin.rem[k][NORM_BITS-1:0], 1'b0} >= {1'b0, fin.n};
      qr     = {1'b0, fin.quo[k]} + (VEC_BITS+1)'(half);
      sat[k] = 1'b0;
      if (fin.neg[k]) begin
        if (qr > LIM) begin
          qr     = LIM;
          sat[k] = 1'b1;
        end
        res[k] = VEC_BITS'(-qr);
      end else begin
        if (qr > LIM - 1'b1) begin
          qr     = LIM - 1'b1;
          sat[k] = 1'b1;
        end
        res[k] = VEC_BITS'(qr);
      end
    end
    if (fin.zero) begin
      out_nxt.rot_x     = '0;
      out_nxt.rot_y     = '0;
      out_nxt.rot_z     = '0;
      out_nxt.zero_quat = 1'b1;
      out_nxt.saturated = 1'b0;
    end else begin
      out_nxt.rot_x     = res[0];
      out_nxt.rot_y     = res[1];
      out_nxt.rot_z     = res[2];
      out_nxt.zero_quat = 1'b0;
      out_nxt.saturated = |sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy[VEC_BITS]) begin
      out_v_r <= v_r[VEC_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[VEC_BITS] && v_r[VEC_BITS-1]) out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

@@ hdl/quaternion_vector_rotation_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotation
// Rotates a 24-bit vector by a Q1.14 quaternion, normalized by its norm.
// ----------------------------------------------------------------------------
// The block accepts one transaction per cycle when the output is not
// stalled, and each passes through these stages: two stages build
// the rotation matrix, three multiply, sum and take magnitudes, 24 stages of
// the restoring divider produce one quotient bit each, and a final stage
// rounds and saturates. Every stage holds while its successor cannot accept,
// so a stall loses nothing and bubbles are squeezed out.
module quaternion_vector_rotation_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qvr_pkg::qvr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qvr_pkg::qvr_out_t out_data
);
  import qvr_pkg::*;

  qvr_mat_t mat;
  qvr_div_t mag;
  logic     mat_valid, mat_ready, mag_valid, mag_ready;

  qvr_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (mat_valid),
    .out_ready (mat_ready),
    .out_data  (mat)
  );

  qvr_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mat_valid),
    .in_ready  (mat_ready),
    .in_data   (mat),
    .out_valid (mag_valid),
    .out_ready (mag_ready),
    .out_data  (mag)
  );

  qvr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mag_valid),
    .in_ready  (mag_ready),
    .in_data   (mag),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
